// ===== src/lept_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lept_pkg
// Shared widths, command and mode codes, easing tables and the control
// interface between the tween timer controller and its datapath.
// ----------------------------------------------------------------------------
package lept_pkg;

  localparam int TIME_BITS = 24;
  localparam int FRAC_BITS = 16;
  localparam int LOOP_BITS = 16;
  localparam int IBITS     = FRAC_BITS - 4;
  localparam int PROG_W    = FRAC_BITS + 1;
  localparam int EASE_W    = FRAC_BITS + 2;
  localparam int DELTA_W   = 16;
  localparam int LIMIT_W   = 17;
  localparam int MODE_W    = 3;
  localparam int CMD_W     = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 24;
  localparam int DIV_STEPS = FRAC_BITS + 1;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_START  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PAUSE  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RESUME = 3'd3;
  localparam logic [CMD_W-1:0] CMD_STOP   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_RESET  = 3'd5;

  localparam logic [MODE_W-1:0] MODE_LINEAR  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_QIN     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_QOUT    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_QINOUT  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_BOUNCE  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_ELASTIC = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_DURATION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOPS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 2'd2;

  typedef struct packed {
    logic capture;
    logic apply;
    logic div_first;
    logic div_step;
    logic ease_a;
    logic ease_b;
    logic ease_c;
    logic finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic advance;
    logic out_free;
  } ctl_stat_t;

  // 2^(-i/16), Q16
  function automatic logic [16:0] exp2_tab(input logic [4:0] i);
    logic [16:0] v;
    case (i)
      5'd0:  v = 17'd65536;
      5'd1:  v = 17'd62757;
      5'd2:  v = 17'd60097;
      5'd3:  v = 17'd57549;
      5'd4:  v = 17'd55109;
      5'd5:  v = 17'd52773;
      5'd6:  v = 17'd50535;
      5'd7:  v = 17'd48393;
      5'd8:  v = 17'd46341;
      5'd9:  v = 17'd44376;
      5'd10: v = 17'd42495;
      5'd11: v = 17'd40693;
      5'd12: v = 17'd38968;
      5'd13: v = 17'd37316;
      5'd14: v = 17'd35734;
      5'd15: v = 17'd34219;
      5'd16: v = 17'd32768;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  // sin(i*pi/32), Q16
  function automatic logic [16:0] sin_tab(input logic [4:0] i);
    logic [16:0] v;
    case (i)
      5'd0:  v = 17'd0;
      5'd1:  v = 17'd6424;
      5'd2:  v = 17'd12785;
      5'd3:  v = 17'd19024;
      5'd4:  v = 17'd25080;
      5'd5:  v = 17'd30893;
      5'd6:  v = 17'd36410;
      5'd7:  v = 17'd41576;
      5'd8:  v = 17'd46341;
      5'd9:  v = 17'd50660;
      5'd10: v = 17'd54491;
      5'd11: v = 17'd57798;
      5'd12: v = 17'd60547;
      5'd13: v = 17'd62714;
      5'd14: v = 17'd64277;
      5'd15: v = 17'd65220;
      5'd16: v = 17'd65536;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== src/lept_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lept_ctrl
// Sequencer: accepts a request, applies it, runs the divider and easing
// steps only for an advancing tick, then waits for the output slot.
// ----------------------------------------------------------------------------
module lept_ctrl
  import lept_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  ctl_stat_t stat,
  output ctl_cmd_t  ctl
);

  typedef enum logic [2:0] {
    S_IDLE, S_APPLY, S_DIV, S_EASE_A, S_EASE_B, S_EASE_C, S_FINISH
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    ctl           = '0;
    ctl.capture   = (state == S_IDLE) && in_valid;
    ctl.apply     = (state == S_APPLY);
    ctl.div_step  = (state == S_DIV);
    ctl.div_first = (state == S_DIV) && (cnt == '0);
    ctl.ease_a    = (state == S_EASE_A);
    ctl.ease_b    = (state == S_EASE_B);
    ctl.ease_c    = (state == S_EASE_C);
    ctl.finish    = (state == S_FINISH) && stat.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_APPLY;
        end
        S_APPLY: begin
          cnt   <= '0;
          state <= stat.advance ? S_DIV : S_FINISH;
        end
        S_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(DIV_STEPS - 1)) state <= S_EASE_A;
        end
        S_EASE_A: state <= S_EASE_B;
        S_EASE_B: state <= S_EASE_C;
        S_EASE_C: state <= S_FINISH;
        S_FINISH: begin
          if (stat.out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/lept_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lept_dp
// Datapath: configuration, timer state, restoring divider, easing
// arithmetic and the output register.
// ----------------------------------------------------------------------------
module lept_dp
  import lept_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  ctl_cmd_t                 ctl,
  output ctl_stat_t                stat,
  input  logic                     cfg_valid,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic [CMD_W-1:0]         cmd,
  input  logic [DELTA_W-1:0]       delta_ticks,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [EASE_W-1:0] eased_value,
  output logic [PROG_W-1:0]        progress,
  output logic                     updated,
  output logic                     loop_wrapped,
  output logic                     done_pulse,
  output logic                     alive
);

  localparam logic [PROG_W-1:0] ONE  = PROG_W'(1) << FRAC_BITS;
  localparam logic [PROG_W-1:0] HALF = PROG_W'(1) << (FRAC_BITS - 1);
  localparam logic [LOOP_BITS-1:0] LOOP_MAX = '1;

  // configuration
  logic [TIME_BITS-1:0]      duration_ticks;
  logic signed [LIMIT_W-1:0] loop_limit;
  logic [MODE_W-1:0]         easing_mode;

  // timer state
  logic [TIME_BITS-1:0] elapsed;
  logic [LOOP_BITS-1:0] loop_index;
  logic running_flag, paused_flag, complete_flag;

  // request
  logic [CMD_W-1:0]   cmd_q;
  logic [DELTA_W-1:0] delta_q;
  logic               adv;

  // divider
  logic [TIME_BITS:0]  rem;
  logic [PROG_W-1:0]   quo;

  // easing
  logic [18:0]         sq_a;
  logic                dbl, lo;
  logic [16:0]         bnc_add;
  logic [3:0]          exp_i;
  logic [4:0]          exp_sh;
  logic [28:0]         exp_prod;
  logic [4:0]          sin_i;
  logic                sin_full;
  logic [28:0]         sin_prod;
  logic                neg;
  logic [37:0]         sq_p;
  logic [16:0]         e_r, s_r;
  logic [33:0]         m;

  logic [TIME_BITS-1:0] dur;
  assign dur = (duration_ticks == '0) ? TIME_BITS'(1) : duration_ticks;

  assign stat.advance  = (cmd_q == CMD_TICK) && running_flag && !paused_flag && !complete_flag;
  assign stat.out_free = !out_valid || !out_stall;

  // tick accumulate with saturation at the duration
  logic [TIME_BITS:0]   sum;
  logic [TIME_BITS-1:0] el_sat;
  assign sum    = {1'b0, elapsed} + {{(TIME_BITS+1-DELTA_W){1'b0}}, delta_q};
  assign el_sat = (sum > {1'b0, dur}) ? dur : sum[TIME_BITS-1:0];

  // one quotient bit per step
  logic [TIME_BITS:0] trial;
  logic               ge;
  assign trial = ctl.div_first ? rem : {rem[TIME_BITS-1:0], 1'b0};
  assign ge    = (trial >= {1'b0, dur});

  // easing operands
  logic [PROG_W-1:0] t, u;
  logic [20:0] t11, t22, kone, bd, ex, eq;
  logic [16:0] ed, sd, sf;
  logic [16:0] bnc_add_n;
  logic [18:0] sq_a_n;
  assign t   = quo;
  assign u   = ONE - t;
  assign t11 = 21'(t) * 21'd11;
  assign t22 = 21'(t) * 21'd22;
  assign ex  = 21'(u) * 21'd10;
  assign eq  = ex + 21'(ONE);
  assign sf  = eq[16] ? (ONE - {1'b0, eq[15:0]}) : {1'b0, eq[15:0]};
  assign ed  = exp2_tab({1'b0, ex[15:12]}) - exp2_tab({1'b0, ex[15:12]} + 5'd1);
  assign sd  = sin_tab(sf[16:12] + 5'd1) - sin_tab(sf[16:12]);
  assign bd  = (t22 >= kone) ? (t22 - kone) : (kone - t22);

  always_comb begin
    if (t11 < 21'(4) * 21'(ONE)) begin
      kone = '0; bnc_add_n = '0;
    end else if (t11 < 21'(8) * 21'(ONE)) begin
      kone = 21'(12) * 21'(ONE); bnc_add_n = 17'(3 * (1 << FRAC_BITS) / 4);
    end else if (t11 < 21'(10) * 21'(ONE)) begin
      kone = 21'(18) * 21'(ONE); bnc_add_n = 17'(15 * (1 << FRAC_BITS) / 16);
    end else begin
      kone = 21'(21) * 21'(ONE); bnc_add_n = 17'(63 * (1 << FRAC_BITS) / 64);
    end
  end

  always_comb begin
    case (easing_mode)
      MODE_QIN:    sq_a_n = 19'(t);
      MODE_QOUT:   sq_a_n = 19'(u);
      MODE_QINOUT: sq_a_n = (t < HALF) ? 19'(t) : 19'(u);
      MODE_BOUNCE: sq_a_n = bd[18:0];
      default:     sq_a_n = '0;
    endcase
  end

  // interpolation and the 2^-ip scale
  logic [16:0] e_base, e_n, s_n;
  logic [17:0] e_y;
  assign e_base = exp2_tab({1'b0, exp_i}) - 17'((exp_prod + 29'(1 << (IBITS-1))) >> IBITS);
  assign e_y    = {e_base, 1'b0} >> exp_sh;
  assign e_n    = (exp_sh == '0) ? e_base : 17'((e_y + 18'd1) >> 1);
  assign s_n    = sin_full ? 17'(ONE)
                : 17'(sin_tab(sin_i) + 17'((sin_prod + 29'(1 << (IBITS-1))) >> IBITS));

  // final easing value
  logic [38:0] sqv;
  logic [PROG_W-1:0] sqr, bq, ev;
  logic signed [EASE_W-1:0] eased_n;
  assign sqv = dbl ? {sq_p, 1'b0} : {1'b0, sq_p};
  assign sqr = PROG_W'((sqv + 39'(HALF)) >> FRAC_BITS);
  assign bq  = PROG_W'((sq_p + (38'd32 << FRAC_BITS)) >> (FRAC_BITS + 6));
  assign ev  = PROG_W'((m + 34'(HALF)) >> FRAC_BITS);

  always_comb begin
    case (easing_mode)
      MODE_QIN:    eased_n = EASE_W'(sqr);
      MODE_QOUT:   eased_n = EASE_W'(ONE) - EASE_W'(sqr);
      MODE_QINOUT: eased_n = lo ? EASE_W'(sqr) : EASE_W'(ONE) - EASE_W'(sqr);
      MODE_BOUNCE: eased_n = EASE_W'(bq) + EASE_W'(bnc_add);
      MODE_ELASTIC: begin
        if (t == '0)      eased_n = '0;
        else if (t[FRAC_BITS]) eased_n = EASE_W'(ONE);
        else if (neg)     eased_n = -EASE_W'(ev);
        else              eased_n = EASE_W'(ev);
      end
      default:     eased_n = EASE_W'(t);
    endcase
  end

  // pass bookkeeping
  logic [LOOP_BITS-1:0] li_n;
  logic full, keep_looping;
  assign full = (elapsed == dur);
  assign li_n = (loop_index < LOOP_MAX) ? loop_index + 1'b1 : loop_index;
  assign keep_looping = loop_limit[LIMIT_W-1] ||
                        ($signed({1'b0, li_n}) < loop_limit);

  always_ff @(posedge clk) begin
    if (rst) begin
      duration_ticks <= TIME_BITS'(1);
      loop_limit     <= LIMIT_W'(1);
      easing_mode    <= MODE_LINEAR;
      elapsed        <= '0;
      loop_index     <= '0;
      running_flag   <= 1'b0;
      paused_flag    <= 1'b0;
      complete_flag  <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_DURATION: duration_ticks <= cfg_data[TIME_BITS-1:0];
          CFG_LOOPS:    loop_limit     <= cfg_data[LIMIT_W-1:0];
          CFG_MODE:     easing_mode    <= cfg_data[MODE_W-1:0];
          default: ;
        endcase
      end

      if (ctl.apply) begin
        if (stat.advance) begin
          elapsed <= el_sat;
        end else begin
          case (cmd_q)
            CMD_START:  begin running_flag <= 1'b1; paused_flag <= 1'b0;
                              complete_flag <= 1'b0; end
            CMD_PAUSE:  paused_flag <= 1'b1;
            CMD_RESUME: paused_flag <= 1'b0;
            CMD_STOP:   begin running_flag <= 1'b0; paused_flag <= 1'b0;
                              complete_flag <= 1'b1; end
            CMD_RESET:  begin elapsed <= '0; loop_index <= '0;
                              complete_flag <= 1'b0; paused_flag <= 1'b0; end
            default: ;
          endcase
        end
      end

      if (ctl.finish) begin
        out_valid <= 1'b1;
        if (adv && full) begin
          loop_index <= li_n;
          if (keep_looping) begin
            elapsed <= '0;
          end else begin
            complete_flag <= 1'b1;
            running_flag  <= 1'b0;
          end
        end
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_q   <= cmd;
      delta_q <= delta_ticks;
    end
    if (ctl.apply) begin
      adv <= stat.advance;
      rem <= {1'b0, el_sat};
      quo <= '0;
    end
    if (ctl.div_step) begin
      rem <= ge ? (trial - {1'b0, dur}) : trial;
      quo <= {quo[PROG_W-2:0], ge};
    end
    if (ctl.ease_a) begin
      sq_a     <= sq_a_n;
      dbl      <= (easing_mode == MODE_QINOUT);
      lo       <= (t < HALF);
      bnc_add  <= bnc_add_n;
      exp_i    <= ex[15:12];
      exp_sh   <= ex[20:16];
      exp_prod <= 29'(ed) * 29'(ex[11:0]);
      sin_i    <= sf[16:12];
      sin_full <= sf[16];
      sin_prod <= 29'(sd) * 29'(sf[11:0]);
      neg      <= eq[17];
    end
    if (ctl.ease_b) begin
      sq_p <= 38'(sq_a) * 38'(sq_a);
      e_r  <= e_n;
      s_r  <= s_n;
    end
    if (ctl.ease_c) begin
      m <= 34'(e_r) * 34'(s_r);
    end
    if (ctl.finish) begin
      eased_value  <= adv ? eased_n : '0;
      progress     <= adv ? quo : '0;
      updated      <= adv;
      loop_wrapped <= adv && full && keep_looping;
      done_pulse   <= adv && full && !keep_looping;
      alive        <= !((adv && full && !keep_looping) || complete_flag);
    end
  end

endmodule

// ===== src/looping_easing_progress_timer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// looping_easing_progress_timer_core
// Tween timer with looping and fixed-point easing curves.
//
//  channel  dir  handshake            payload
//  in       in   in_valid/in_stall    cmd, delta_ticks
//  out      out  out_valid/out_stall  eased_value, progress, updated,
//                                     loop_wrapped, done_pulse, alive
//  cfg      in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A tick that advances the timer passes through the apply step, the
// bit-serial progress divider, the easing steps and the output load; other
// commands go from apply straight to the output load. The sequencer then
// returns to idle and takes the next request. One request is in flight at a
// time. Reset is synchronous and clears state and config to defaults. A
// stalled result holds the sequencer in its last step.
// ----------------------------------------------------------------------------
module looping_easing_progress_timer_core
  import lept_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [CMD_W-1:0]         cmd,
  input  logic [DELTA_W-1:0]       delta_ticks,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [EASE_W-1:0] eased_value,
  output logic [PROG_W-1:0]        progress,
  output logic                     updated,
  output logic                     loop_wrapped,
  output logic                     done_pulse,
  output logic                     alive,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data
);

  ctl_cmd_t  ctl;
  ctl_stat_t stat;

  assign cfg_ready = 1'b1;

  lept_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .ctl      (ctl)
  );

  lept_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .stat         (stat),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .delta_ticks  (delta_ticks),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .eased_value  (eased_value),
    .progress     (progress),
    .updated      (updated),
    .loop_wrapped (loop_wrapped),
    .done_pulse   (done_pulse),
    .alive        (alive)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while previous one in flight");

  a_wrap_xor_done: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(loop_wrapped && done_pulse))
    else $error("wrap and completion on the same result");

  a_done_not_alive: assert property (@(posedge clk) disable iff (rst)
    (out_valid && done_pulse) |-> !alive)
    else $error("completion reported while still alive");

  a_idle_result_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !updated) |-> (progress == '0 && !loop_wrapped && !done_pulse))
    else $error("non-advancing result carries data");

endmodule
